// ----- hw/rtl/scs_cn_pkg.sv -----
// shared types and constants for the curve number runoff unit
package scs_cn_pkg;

  localparam int FRAC_BITS = 8;

  localparam int P_W   = 24;
  localparam int CN_W  = 16;
  localparam int C5_W  = 18;
  localparam int K_W   = 24;
  localparam int AB_W  = 52;
  localparam int A_W   = 41;
  localparam int AL_W  = 21;
  localparam int AH_W  = A_W - AL_W;
  localparam int B_W   = 50;
  localparam int BL_W  = 25;
  localparam int BH_W  = B_W - BL_W;
  localparam int N_W   = 2 * A_W;
  localparam int D_W   = C5_W + B_W;
  localparam int Q_W   = 24;
  localparam int R_W   = D_W + Q_W;
  localparam int DIV_STAGES = Q_W;

  localparam logic signed [CN_W-1:0] CN_MAX = CN_W'(100 * (1 << FRAC_BITS));
  localparam logic [K_W-1:0] K_FULL = K_W'(100 * (1 << FRAC_BITS));

  localparam int OUT_MAX_INT = (1 << (P_W - 1)) - 1;
  localparam int OUT_MIN_INT = -(1 << (P_W - 1));
  localparam int ND_INT = -9999 * (1 << FRAC_BITS);
  localparam logic signed [P_W-1:0] ND_RUNOFF =
    (ND_INT < OUT_MIN_INT) ? P_W'(OUT_MIN_INT) : P_W'(ND_INT);
  localparam logic [Q_W:0] OUT_MAX = (Q_W+1)'(OUT_MAX_INT);

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_P_EN  = 2'd0;
  localparam logic [1:0] REG_P_ND  = 2'd1;
  localparam logic [1:0] REG_CN_EN = 2'd2;
  localparam logic [1:0] REG_CN_ND = 2'd3;

  typedef struct packed {
    logic           nd;
    logic           zero;
    logic [D_W-1:0] d;
    logic [R_W-1:0] rem;
    logic [Q_W-1:0] q;
  } div_data_t;

endpackage

// ----- hw/rtl/scs_cn_if.sv -----
// channel interfaces for the curve number runoff unit
interface scs_cn_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [scs_cn_pkg::P_W-1:0]     precip_mm;
  logic signed [scs_cn_pkg::CN_W-1:0]    curve_number;
  modport source(output valid, precip_mm, curve_number, input ready);
  modport sink(input valid, precip_mm, curve_number, output ready);
endinterface

interface scs_cn_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [scs_cn_pkg::P_W-1:0]     runoff_mm;
  logic                                  is_nodata;
  modport source(output valid, runoff_mm, is_nodata, input ready);
  modport sink(input valid, runoff_mm, is_nodata, output ready);
endinterface

// ----- hw/rtl/scs_curve_number_runoff_unit.sv -----
// curve number runoff unit, top level
// pipeline: 5 arithmetic stages, 24 divider stages, output register
// throughput: one transaction per cycle; the whole pipeline holds while a result waits
// reset: synchronous active-low rst_n clears valid bits and config registers
module scs_curve_number_runoff_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  scs_cn_in_if.sink                         in_ch,
  scs_cn_out_if.source                      out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scs_cn_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // config registers
  logic                                p_en_r;
  logic signed [scs_cn_pkg::P_W-1:0]   p_nd_r;
  logic                                cn_en_r;
  logic signed [scs_cn_pkg::CN_W-1:0]  cn_nd_r;
  logic                                wr_en;
  logic [1:0]                          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_en_r  <= 1'b0;
      p_nd_r  <= '0;
      cn_en_r <= 1'b0;
      cn_nd_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        scs_cn_pkg::REG_P_EN:  p_en_r  <= pwdata[0];
        scs_cn_pkg::REG_P_ND:  p_nd_r  <= pwdata[scs_cn_pkg::P_W-1:0];
        scs_cn_pkg::REG_CN_EN: cn_en_r <= pwdata[0];
        scs_cn_pkg::REG_CN_ND: cn_nd_r <= pwdata[scs_cn_pkg::CN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      scs_cn_pkg::REG_P_EN:  prdata = {31'd0, p_en_r};
      scs_cn_pkg::REG_P_ND:  prdata = {{(32-scs_cn_pkg::P_W){1'b0}}, p_nd_r};
      scs_cn_pkg::REG_CN_EN: prdata = {31'd0, cn_en_r};
      scs_cn_pkg::REG_CN_ND: prdata = {{(32-scs_cn_pkg::CN_W){1'b0}}, cn_nd_r};
      default:               prdata = '0;
    endcase
  end

  // pipeline control
  logic out_v_r;
  logic en;
  assign en = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: capture and classify
  logic                                s1_v_r, s1_nd_r, s1_z_r;
  logic signed [scs_cn_pkg::P_W-1:0]   s1_p_r;
  logic signed [scs_cn_pkg::CN_W-1:0]  s1_c_r;
  logic                                nd_hit, bad_in;

  assign nd_hit = (p_en_r && in_ch.precip_mm == p_nd_r) ||
                  (cn_en_r && in_ch.curve_number == cn_nd_r);
  assign bad_in = (in_ch.curve_number <= 0) || (in_ch.curve_number > scs_cn_pkg::CN_MAX) ||
                  (in_ch.precip_mm <= 0);

  // stage 2: 5*c*p and 254*K*2^F
  logic                                s2_v_r, s2_nd_r, s2_z_r;
  logic signed [scs_cn_pkg::AB_W-1:0]  s2_cp5_r;
  logic signed [scs_cn_pkg::AB_W-1:0]  s2_kk_r;
  logic [scs_cn_pkg::C5_W-1:0]         s2_c5_r;
  logic [scs_cn_pkg::C5_W-1:0]         c5;
  logic [scs_cn_pkg::K_W-1:0]          kval;

  assign c5   = scs_cn_pkg::C5_W'(s1_c_r[scs_cn_pkg::CN_W-2:0]) * scs_cn_pkg::C5_W'(5);
  assign kval = scs_cn_pkg::K_FULL - scs_cn_pkg::K_W'(s1_c_r[scs_cn_pkg::CN_W-2:0]);

  // stage 3: a and b
  logic                                s3_v_r, s3_nd_r, s3_z_r;
  logic [scs_cn_pkg::A_W-1:0]          s3_a_r;
  logic [scs_cn_pkg::B_W-1:0]          s3_b_r;
  logic [scs_cn_pkg::C5_W-1:0]         s3_c5_r;
  logic signed [scs_cn_pkg::AB_W-1:0]  a_val, b_val;

  assign a_val = s2_cp5_r - s2_kk_r;
  assign b_val = s2_cp5_r + (s2_kk_r <<< 2);

  // stage 4: partial products
  logic                                          s4_v_r, s4_nd_r, s4_z_r;
  logic [2*scs_cn_pkg::AH_W-1:0]                 s4_hh_r;
  logic [scs_cn_pkg::AH_W+scs_cn_pkg::AL_W-1:0]  s4_hl_r;
  logic [2*scs_cn_pkg::AL_W-1:0]                 s4_ll_r;
  logic [scs_cn_pkg::C5_W+scs_cn_pkg::BH_W-1:0]  s4_cbh_r;
  logic [scs_cn_pkg::C5_W+scs_cn_pkg::BL_W-1:0]  s4_cbl_r;
  logic [scs_cn_pkg::AH_W-1:0]                   a_hi;
  logic [scs_cn_pkg::AL_W-1:0]                   a_lo;

  assign a_hi = s3_a_r[scs_cn_pkg::A_W-1:scs_cn_pkg::AL_W];
  assign a_lo = s3_a_r[scs_cn_pkg::AL_W-1:0];

  // stage 5: numerator and denominator
  logic                  s5_v_r;
  scs_cn_pkg::div_data_t s5_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_nd_r  <= nd_hit;
      s1_z_r   <= bad_in;
      s1_p_r   <= in_ch.precip_mm;
      s1_c_r   <= in_ch.curve_number;

      s2_nd_r  <= s1_nd_r;
      s2_z_r   <= s1_z_r;
      s2_c5_r  <= c5;
      s2_cp5_r <= scs_cn_pkg::AB_W'(signed'({1'b0, c5})) * scs_cn_pkg::AB_W'(s1_p_r);
      s2_kk_r  <= (scs_cn_pkg::AB_W'(kval) * scs_cn_pkg::AB_W'(254)) <<< scs_cn_pkg::FRAC_BITS;

      s3_nd_r  <= s2_nd_r;
      s3_z_r   <= s2_z_r || (a_val <= 0);
      s3_a_r   <= a_val[scs_cn_pkg::A_W-1:0];
      s3_b_r   <= b_val[scs_cn_pkg::B_W-1:0];
      s3_c5_r  <= s2_c5_r;

      s4_nd_r  <= s3_nd_r;
      s4_z_r   <= s3_z_r;
      s4_hh_r  <= a_hi * a_hi;
      s4_hl_r  <= a_hi * a_lo;
      s4_ll_r  <= a_lo * a_lo;
      s4_cbh_r <= s3_c5_r * s3_b_r[scs_cn_pkg::B_W-1:scs_cn_pkg::BL_W];
      s4_cbl_r <= s3_c5_r * s3_b_r[scs_cn_pkg::BL_W-1:0];

      s5_d_r.nd   <= s4_nd_r;
      s5_d_r.zero <= s4_z_r;
      s5_d_r.q    <= '0;
      s5_d_r.rem  <= scs_cn_pkg::R_W'((scs_cn_pkg::N_W'(s4_hh_r) << (2*scs_cn_pkg::AL_W)) +
                     (scs_cn_pkg::N_W'(s4_hl_r) << (scs_cn_pkg::AL_W + 1)) +
                     scs_cn_pkg::N_W'(s4_ll_r));
      s5_d_r.d    <= (scs_cn_pkg::D_W'(s4_cbh_r) << scs_cn_pkg::BL_W) +
                     scs_cn_pkg::D_W'(s4_cbl_r);
    end
  end

  // divider
  logic                  dv_v;
  scs_cn_pkg::div_data_t dv_d;

  scs_cn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (s5_v_r),
    .in_d  (s5_d_r),
    .out_v (dv_v),
    .out_d (dv_d)
  );

  // rounding and output register
  logic                              out_nd_r;
  logic signed [scs_cn_pkg::P_W-1:0] out_runoff_r;
  logic [scs_cn_pkg::Q_W:0]          q_rnd;
  logic signed [scs_cn_pkg::P_W-1:0] res_nxt;

  always_comb begin
    q_rnd = {1'b0, dv_d.q} +
            (scs_cn_pkg::Q_W+1)'({dv_d.rem[scs_cn_pkg::D_W-1:0], 1'b0} >= {1'b0, dv_d.d});
    if (dv_d.nd) begin
      res_nxt = scs_cn_pkg::ND_RUNOFF;
    end else if (dv_d.zero) begin
      res_nxt = '0;
    end else if (q_rnd > scs_cn_pkg::OUT_MAX) begin
      res_nxt = scs_cn_pkg::P_W'(scs_cn_pkg::OUT_MAX);
    end else begin
      res_nxt = q_rnd[scs_cn_pkg::P_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_nd_r     <= dv_d.nd;
      out_runoff_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.is_nodata = out_nd_r;
  assign out_ch.runoff_mm = out_runoff_r;

  a_nd_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_nodata |-> out_ch.runoff_mm == scs_cn_pkg::ND_RUNOFF)
    else $error("nodata result carries wrong value");

  a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.is_nodata |-> !out_ch.runoff_mm[scs_cn_pkg::P_W-1])
    else $error("runoff is negative");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !s1_v_r && !s5_v_r)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> $stable(s5_v_r) && $stable(dv_v))
    else $error("pipeline moved during stall");

endmodule

// ----- hw/rtl/scs_cn_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module scs_cn_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_v,
  input  scs_cn_pkg::div_data_t in_d,
  output logic                  out_v,
  output scs_cn_pkg::div_data_t out_d
);

  localparam int NS = scs_cn_pkg::DIV_STAGES;

  logic                  v_r [NS];
  scs_cn_pkg::div_data_t d_r [NS];
  scs_cn_pkg::div_data_t d_nxt [NS];

  always_comb begin
    scs_cn_pkg::div_data_t prev;
    logic [scs_cn_pkg::R_W-1:0] trial;
    for (int i = 0; i < NS; i++) begin
      prev = (i == 0) ? in_d : d_r[(i == 0) ? 0 : i - 1];
      trial = scs_cn_pkg::R_W'(prev.d) << (NS - 1 - i);
      d_nxt[i] = prev;
      if (prev.rem >= trial) begin
        d_nxt[i].rem = prev.rem - trial;
        d_nxt[i].q[NS - 1 - i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int i = 1; i < NS; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) d_r[i] <= d_nxt[i];
    end
  end

  assign out_v = v_r[NS-1];
  assign out_d = d_r[NS-1];

endmodule
